// ----- rtl/core/kcv_pkg.sv -----
// Shared types, constants and helper functions of the 3D constant-velocity Kalman tracker.
`default_nettype none

package kcv_pkg;

	localparam int CFG_AW   = 2;
	localparam int CFG_DW   = 47;
	localparam int DT_W     = 31;
	localparam int ST_W     = 32;
	localparam int COV_W    = 48;
	localparam int TERM_W   = 62;
	localparam int GAIN_FB  = 32;
	localparam int DEN_W    = 50;
	localparam int DIV_BITS = 62;
	localparam int DIV_CW   = 6;

	localparam logic [DT_W-1:0]   DT_RST = 31'd6554;
	localparam logic [CFG_DW-1:0] Q_RST  = 47'd42950;
	localparam logic [CFG_DW-1:0] R_RST  = 47'd429496730;
	localparam logic [CFG_DW-1:0] P0_RST = 47'd4294967296000;

	typedef enum logic [CFG_AW-1:0] {
		CFG_DT = 2'd0,
		CFG_Q  = 2'd1,
		CFG_R  = 2'd2,
		CFG_P0 = 2'd3
	} kcv_cfg_t;

	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_PRED_P  = 4'd1,
		OP_PRED_TA = 4'd2,
		OP_PRED_TB = 4'd3,
		OP_PRED_PP = 4'd4,
		OP_PRED_VV = 4'd5,
		OP_UPD_P   = 4'd6,
		OP_UPD_V   = 4'd7,
		OP_UPD_VV  = 4'd8,
		OP_UPD_PV  = 4'd9,
		OP_UPD_PP  = 4'd10
	} kcv_op_t;

	typedef struct packed {
		kcv_op_t op;
		logic    mul_start;
		logic    div_start;
		logic    accept;
		logic    load;
		logic    store;
		logic    emit;
	} kcv_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic s_pos;
		logic coast;
	} kcv_sts_t;

	typedef struct packed {
		logic                     sat;
		logic signed [TERM_W-1:0] val;
	} kcv_term_t;

	function automatic logic ovf_w(input logic signed [63:0] x, input int w);
		logic signed [63:0] hi;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		return (x > hi) || (x < (-hi - 64'sd1));
	endfunction

	function automatic logic signed [63:0] clip_w(input logic signed [63:0] x, input int w);
		logic signed [63:0] hi;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		if (x > hi)
			return hi;
		else if (x < (-hi - 64'sd1))
			return -hi - 64'sd1;
		return x;
	endfunction

	// magnitude plus sign to a 62-bit signed term, clipped
	function automatic kcv_term_t fin_term(input logic [63:0] mag, input logic over,
			input logic neg);
		kcv_term_t t;
		logic [63:0] lim;
		lim = 64'd1 << (TERM_W - 1);
		t.sat = 1'b0;
		if (neg) begin
			if (over || mag > lim) begin
				t.sat = 1'b1;
				t.val = {1'b1, {(TERM_W-1){1'b0}}};
			end else begin
				t.val = -$signed(mag[TERM_W-1:0]);
			end
		end else begin
			if (over || mag > lim - 64'd1) begin
				t.sat = 1'b1;
				t.val = {1'b0, {(TERM_W-1){1'b1}}};
			end else begin
				t.val = $signed(mag[TERM_W-1:0]);
			end
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/kcv_mul.sv -----
// Multi-cycle signed multiplier with rounding shift and 62-bit clipping.
`default_nettype none

module kcv_mul #(
	parameter int SFB = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        gain,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output kcv_pkg::kcv_term_t res
);
	import kcv_pkg::*;

	logic [63:0]  ma, mb;
	logic [63:0]  ma_q, mb_q;
	logic         neg_q, gain_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, fin_q, done_q;
	kcv_term_t    res_q;
	logic [79:0]  prod;
	logic [127:0] rnd, shf;

	assign ma = a[63] ? (64'd0 - a) : a;
	assign mb = b[63] ? (64'd0 - b) : b;
	assign prod = ma_q * mb_q[63:48];

	always_comb begin
		if (gain_q) begin
			rnd = acc_q + (128'd1 << (GAIN_FB - 1));
			shf = rnd >> GAIN_FB;
		end else begin
			rnd = acc_q + (128'd1 << (SFB - 1));
			shf = rnd >> SFB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q && (cnt_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q   <= ma;
			mb_q   <= mb;
			neg_q  <= a[63] ^ b[63];
			gain_q <= gain;
			acc_q  <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[111:0], 16'd0} + {48'd0, prod};
			mb_q  <= {mb_q[47:0], 16'd0};
		end
		if (fin_q)
			res_q <= fin_term(shf[63:0], |shf[127:64], neg_q);
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/kcv_div.sv -----
// Two-lane restoring divider giving rounded Q.32 gains over a shared denominator.
`default_nettype none

module kcv_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic signed [kcv_pkg::COV_W-1:0] num_a,
	input  wire logic signed [kcv_pkg::COV_W-1:0] num_b,
	input  wire logic [kcv_pkg::DEN_W-1:0]        den,
	output logic                                 done,
	output kcv_pkg::kcv_term_t                   qa,
	output kcv_pkg::kcv_term_t                   qb
);
	import kcv_pkg::*;

	logic [COV_W-1:0]    mag [2];
	logic [DEN_W-1:0]    rem_q [2];
	logic [DIV_BITS-1:0] dvd_q [2];
	logic [DIV_BITS-1:0] quo_q [2];
	logic                ovf_q [2];
	logic                neg_q [2];
	logic [DEN_W-1:0]    den_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic                busy_q, fin_q, done_q;
	kcv_term_t           res_q [2];
	logic [DEN_W:0]      rem2 [2];
	logic                ge [2];
	logic [DEN_W:0]      sub [2];
	logic                rup [2];
	logic [DIV_BITS:0]   qr [2];

	assign mag[0] = num_a[COV_W-1] ? (COV_W'(0) - num_a) : num_a;
	assign mag[1] = num_b[COV_W-1] ? (COV_W'(0) - num_b) : num_b;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rem2[i] = {rem_q[i], dvd_q[i][DIV_BITS-1]};
			ge[i]   = rem2[i] >= {1'b0, den_q};
			sub[i]  = rem2[i] - {1'b0, den_q};
			rup[i]  = {rem_q[i], 1'b0} >= {1'b0, den_q};
			qr[i]   = {1'b0, quo_q[i]} + (DIV_BITS+1)'(rup[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q && (cnt_q == DIV_CW'(DIV_BITS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CW'(1);
				if (cnt_q == DIV_CW'(DIV_BITS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= DEN_W'(mag[i] >> 30);
				ovf_q[i] <= DEN_W'(mag[i] >> 30) >= den;
				dvd_q[i] <= {mag[i][29:0], 32'd0};
				quo_q[i] <= '0;
			end
			neg_q[0] <= num_a[COV_W-1];
			neg_q[1] <= num_b[COV_W-1];
		end else if (busy_q) begin
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= ge[i] ? sub[i][DEN_W-1:0] : rem2[i][DEN_W-1:0];
				dvd_q[i] <= {dvd_q[i][DIV_BITS-2:0], 1'b0};
				quo_q[i] <= {quo_q[i][DIV_BITS-2:0], ge[i]};
			end
		end
		if (fin_q) begin
			for (int i = 0; i < 2; i++)
				res_q[i] <= fin_term(64'(qr[i]), ovf_q[i], neg_q[i]);
		end
	end

	assign done = done_q;
	assign qa   = res_q[0];
	assign qb   = res_q[1];

endmodule

`default_nettype wire

// ----- rtl/core/kcv_dp.sv -----
// Tracker datapath: config registers, per-axis state, working registers, multiplier and divider.
`default_nettype none

module kcv_dp #(
	parameter int NUM_AXES        = 3,
	parameter int STATE_FRAC_BITS = 16,
	parameter int AXW             = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [kcv_pkg::CFG_AW-1:0]     cfg_addr,
	input  wire logic [kcv_pkg::CFG_DW-1:0]     cfg_wdata,
	input  wire logic                          action,
	input  wire logic signed [31:0]            meas_x,
	input  wire logic signed [31:0]            meas_y,
	input  wire logic signed [31:0]            meas_z,
	input  wire kcv_pkg::kcv_cmd_t             cmd,
	input  wire logic [AXW-1:0]                axis,
	output kcv_pkg::kcv_sts_t                  sts,
	output logic signed [31:0]                 pos_x,
	output logic signed [31:0]                 pos_y,
	output logic signed [31:0]                 pos_z,
	output logic signed [31:0]                 vel_x,
	output logic signed [31:0]                 vel_y,
	output logic signed [31:0]                 vel_z,
	output logic                               saturated
);
	import kcv_pkg::*;

	logic [DT_W-1:0]   dt_q;
	logic [CFG_DW-1:0] q_q, r_q, p0_q;

	logic signed [ST_W-1:0]  p_q   [NUM_AXES];
	logic signed [ST_W-1:0]  v_q   [NUM_AXES];
	logic signed [COV_W-1:0] pp_q  [NUM_AXES];
	logic signed [COV_W-1:0] pv_q  [NUM_AXES];
	logic signed [COV_W-1:0] vv_q  [NUM_AXES];

	logic signed [ST_W-1:0]   wp_q, wv_q;
	logic signed [COV_W-1:0]  wpp_q, wpv_q, wvv_q, ta_q;
	logic signed [TERM_W-1:0] kp_q, kv_q;
	logic signed [ST_W:0]     y_q;
	logic signed [DEN_W-1:0]  s_q;
	logic signed [ST_W-1:0]   meas_q [3];
	logic                     coast_q, sat_q, osat_q;
	logic signed [ST_W-1:0]   opos_q [3];
	logic signed [ST_W-1:0]   ovel_q [3];

	logic        mul_gain, mul_done, div_done;
	logic [63:0] mul_a, mul_b;
	kcv_term_t   mul_res, div_qa, div_qb;
	logic signed [63:0] t64, sum, clp;
	logic        narrow, apply, ovf;
	logic signed [ST_W-1:0] z;

	kcv_mul #(.SFB(STATE_FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.gain   (mul_gain),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	kcv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num_a  (wpp_q),
		.num_b  (wpv_q),
		.den    (s_q),
		.done   (div_done),
		.qa     (div_qa),
		.qb     (div_qb)
	);

	// multiplier operand routing
	always_comb begin
		mul_a    = $signed({33'd0, dt_q});
		mul_b    = '0;
		mul_gain = 1'b0;
		case (cmd.op)
			OP_PRED_P:  mul_b = 64'(wv_q);
			OP_PRED_TA: mul_b = 64'(wpv_q);
			OP_PRED_TB: mul_b = 64'(wvv_q);
			OP_PRED_PP: mul_b = 64'(wpv_q);
			OP_UPD_P: begin
				mul_a = 64'(kp_q); mul_b = 64'(y_q); mul_gain = 1'b1;
			end
			OP_UPD_V: begin
				mul_a = 64'(kv_q); mul_b = 64'(y_q); mul_gain = 1'b1;
			end
			OP_UPD_VV: begin
				mul_a = 64'(kv_q); mul_b = 64'(wpv_q); mul_gain = 1'b1;
			end
			OP_UPD_PV: begin
				mul_a = 64'(kp_q); mul_b = 64'(wpv_q); mul_gain = 1'b1;
			end
			OP_UPD_PP: begin
				mul_a = 64'(kp_q); mul_b = 64'(wpp_q); mul_gain = 1'b1;
			end
			default: ;
		endcase
	end

	// add or subtract each product into the working value; the velocity-variance predict adds q alone
	always_comb begin
		t64    = 64'(mul_res.val);
		sum    = '0;
		narrow = 1'b0;
		case (cmd.op)
			OP_PRED_P:  begin sum = 64'(wp_q) + t64; narrow = 1'b1; end
			OP_PRED_TA: sum = 64'(wpp_q) + t64;
			OP_PRED_TB: sum = 64'(wpv_q) + t64;
			OP_PRED_PP: sum = 64'(ta_q) + t64 + $signed({17'd0, q_q});
			OP_PRED_VV: sum = 64'(wvv_q) + $signed({17'd0, q_q});
			OP_UPD_P:   begin sum = 64'(wp_q) + t64; narrow = 1'b1; end
			OP_UPD_V:   begin sum = 64'(wv_q) + t64; narrow = 1'b1; end
			OP_UPD_VV:  sum = 64'(wvv_q) - t64;
			OP_UPD_PV:  sum = 64'(wpv_q) - t64;
			OP_UPD_PP:  sum = 64'(wpp_q) - t64;
			default: ;
		endcase
		ovf   = narrow ? ovf_w(sum, ST_W) : ovf_w(sum, COV_W);
		clp   = narrow ? clip_w(sum, ST_W) : clip_w(sum, COV_W);
		apply = (cmd.op == OP_PRED_VV) || (mul_done && cmd.op != OP_NONE);
	end

	always_comb begin
		z = '0;
		for (int i = 0; i < 3; i++)
			if (int'(axis) == i)
				z = meas_q[i];
	end

	// configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RST;
			q_q  <= Q_RST;
			r_q  <= R_RST;
			p0_q <= P0_RST;
			for (int i = 0; i < NUM_AXES; i++) begin
				p_q[i]  <= '0;
				v_q[i]  <= '0;
				pp_q[i] <= $signed({1'b0, P0_RST});
				pv_q[i] <= '0;
				vv_q[i] <= $signed({1'b0, P0_RST});
			end
		end else begin
			if (cfg_wen) begin
				case (kcv_cfg_t'(cfg_addr))
					CFG_DT: dt_q <= cfg_wdata[DT_W-1:0];
					CFG_Q:  q_q  <= cfg_wdata;
					CFG_R:  r_q  <= cfg_wdata;
					CFG_P0: p0_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cfg_wen && kcv_cfg_t'(cfg_addr) == CFG_P0) begin
				for (int i = 0; i < NUM_AXES; i++) begin
					p_q[i]  <= '0;
					v_q[i]  <= '0;
					pp_q[i] <= $signed({1'b0, cfg_wdata});
					pv_q[i] <= '0;
					vv_q[i] <= $signed({1'b0, cfg_wdata});
				end
			end else if (cmd.store) begin
				p_q[axis]  <= wp_q;
				v_q[axis]  <= wv_q;
				pp_q[axis] <= wpp_q;
				pv_q[axis] <= wpv_q;
				vv_q[axis] <= wvv_q;
			end
		end
	end

	// working registers for the axis in flight
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			meas_q[0] <= meas_x;
			meas_q[1] <= meas_y;
			meas_q[2] <= meas_z;
			coast_q   <= action;
			sat_q     <= 1'b0;
		end
		if (cmd.load) begin
			wp_q  <= p_q[axis];
			wv_q  <= v_q[axis];
			wpp_q <= pp_q[axis];
			wpv_q <= pv_q[axis];
			wvv_q <= vv_q[axis];
		end
		if (apply) begin
			if (ovf || (mul_done && mul_res.sat))
				sat_q <= 1'b1;
			case (cmd.op)
				OP_PRED_P, OP_UPD_P: wp_q <= clp[ST_W-1:0];
				OP_UPD_V:            wv_q <= clp[ST_W-1:0];
				OP_PRED_TA:          ta_q <= clp[COV_W-1:0];
				OP_PRED_TB, OP_UPD_PV: wpv_q <= clp[COV_W-1:0];
				OP_PRED_PP, OP_UPD_PP: wpp_q <= clp[COV_W-1:0];
				OP_PRED_VV, OP_UPD_VV: wvv_q <= clp[COV_W-1:0];
				default: ;
			endcase
		end
		if (cmd.op == OP_PRED_VV) begin
			s_q <= DEN_W'(wpp_q) + $signed({3'd0, r_q});
			y_q <= (ST_W+1)'(z) - (ST_W+1)'(wp_q);
		end
		if (div_done) begin
			kp_q <= div_qa.val;
			kv_q <= div_qb.val;
			if (div_qa.sat || div_qb.sat)
				sat_q <= 1'b1;
		end
		if (cmd.emit)
			osat_q <= sat_q;
	end

	for (genvar gi = 0; gi < 3; gi++) begin : g_out
		if (gi < NUM_AXES) begin : g_live
			always_ff @(posedge clk) begin
				if (cmd.emit) begin
					opos_q[gi] <= p_q[gi];
					ovel_q[gi] <= v_q[gi];
				end
			end
		end else begin : g_none
			assign opos_q[gi] = '0;
			assign ovel_q[gi] = '0;
		end
	end

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign sts.s_pos    = !s_q[DEN_W-1] && (s_q != '0);
	assign sts.coast    = coast_q;

	assign pos_x     = opos_q[0];
	assign pos_y     = opos_q[1];
	assign pos_z     = opos_q[2];
	assign vel_x     = ovel_q[0];
	assign vel_y     = ovel_q[1];
	assign vel_z     = ovel_q[2];
	assign saturated = osat_q;

endmodule

`default_nettype wire

// ----- rtl/core/kcv_ctrl.sv -----
// Tracker sequencer: walks each axis through predict and, unless coasting or S is not positive, gain and update steps.
`default_nettype none

module kcv_ctrl #(
	parameter int NUM_AXES = 3,
	parameter int AXW      = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire kcv_pkg::kcv_sts_t sts,
	output kcv_pkg::kcv_cmd_t      cmd,
	output logic [AXW-1:0]         axis
);
	import kcv_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_LOAD  = 16'h0002,
		S_PP    = 16'h0004,
		S_PTA   = 16'h0008,
		S_PTB   = 16'h0010,
		S_PPP   = 16'h0020,
		S_PVV   = 16'h0040,
		S_CHK   = 16'h0080,
		S_DIV   = 16'h0100,
		S_UP    = 16'h0200,
		S_UV    = 16'h0400,
		S_UVV   = 16'h0800,
		S_UPV   = 16'h1000,
		S_UPP   = 16'h2000,
		S_STORE = 16'h4000,
		S_EMIT  = 16'h8000
	} kcv_state_t;

	kcv_state_t state_q, state_d;
	logic [AXW-1:0] ax_q;
	logic issued_q, oval_q, is_mul, last_ax, emit_ok;

	assign last_ax = (ax_q == AXW'(NUM_AXES - 1));
	assign emit_ok = !oval_q || out_ready;

	always_comb begin
		cmd       = '0;
		cmd.op    = OP_NONE;
		is_mul    = 1'b0;
		state_d   = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid)
					state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_PP;
			end
			S_PP:  begin cmd.op = OP_PRED_P;  is_mul = 1'b1; if (sts.mul_done) state_d = S_PTA; end
			S_PTA: begin cmd.op = OP_PRED_TA; is_mul = 1'b1; if (sts.mul_done) state_d = S_PTB; end
			S_PTB: begin cmd.op = OP_PRED_TB; is_mul = 1'b1; if (sts.mul_done) state_d = S_PPP; end
			S_PPP: begin cmd.op = OP_PRED_PP; is_mul = 1'b1; if (sts.mul_done) state_d = S_PVV; end
			S_PVV: begin
				cmd.op  = OP_PRED_VV;
				state_d = S_CHK;
			end
			S_CHK: state_d = (!sts.coast && sts.s_pos) ? S_DIV : S_STORE;
			S_DIV: begin
				cmd.div_start = !issued_q;
				if (sts.div_done)
					state_d = S_UP;
			end
			S_UP:  begin cmd.op = OP_UPD_P;  is_mul = 1'b1; if (sts.mul_done) state_d = S_UV;  end
			S_UV:  begin cmd.op = OP_UPD_V;  is_mul = 1'b1; if (sts.mul_done) state_d = S_UVV; end
			S_UVV: begin cmd.op = OP_UPD_VV; is_mul = 1'b1; if (sts.mul_done) state_d = S_UPV; end
			S_UPV: begin cmd.op = OP_UPD_PV; is_mul = 1'b1; if (sts.mul_done) state_d = S_UPP; end
			S_UPP: begin cmd.op = OP_UPD_PP; is_mul = 1'b1; if (sts.mul_done) state_d = S_STORE; end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = last_ax ? S_EMIT : S_LOAD;
			end
			S_EMIT: begin
				cmd.emit = emit_ok;
				if (emit_ok)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		cmd.mul_start = is_mul && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ax_q     <= '0;
			issued_q <= 1'b0;
			oval_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mul_start || cmd.div_start)
				issued_q <= 1'b1;
			else if (sts.mul_done || sts.div_done)
				issued_q <= 1'b0;
			if (cmd.accept)
				ax_q <= '0;
			else if (cmd.store && !last_ax)
				ax_q <= ax_q + AXW'(1);
			if (cmd.emit)
				oval_q <= 1'b1;
			else if (out_ready)
				oval_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = oval_q;
	assign axis      = ax_q;

endmodule

`default_nettype wire

// ----- rtl/core/kalman_cv_tracker_3d.sv -----
// Top level of the three-axis constant-velocity Kalman tracker.
//
//  channel  | handshake            | words
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | action, meas_x, meas_y, meas_z
//  output   | out_valid / out_ready| pos_x..z, vel_x..z, saturated
//  config   | cfg_wen (no stall)   | cfg_addr, cfg_wdata
//
// One word at a time. Per axis the predict pass runs first and the update
// follows: the shared multiplier forms one product at a time, the gain
// divider gives one quotient bit per cycle. Reset needs no clearing pass.
// A finished word waits in the output register while the next input word is taken;
// the last step stalls only if it is still unread.
`default_nettype none

module kalman_cv_tracker_3d #(
	parameter int NUM_AXES        = 3,
	parameter int STATE_FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wen,
	input  wire logic [kcv_pkg::CFG_AW-1:0] cfg_addr,
	input  wire logic [kcv_pkg::CFG_DW-1:0] cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      action,
	input  wire logic signed [31:0]        meas_x,
	input  wire logic signed [31:0]        meas_y,
	input  wire logic signed [31:0]        meas_z,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [31:0]             pos_x,
	output logic signed [31:0]             pos_y,
	output logic signed [31:0]             pos_z,
	output logic signed [31:0]             vel_x,
	output logic signed [31:0]             vel_y,
	output logic signed [31:0]             vel_z,
	output logic                           saturated
);
	import kcv_pkg::*;

	localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	kcv_cmd_t       cmd;
	kcv_sts_t       sts;
	logic [AXW-1:0] axis;

	kcv_ctrl #(.NUM_AXES(NUM_AXES), .AXW(AXW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd),
		.axis      (axis)
	);

	kcv_dp #(.NUM_AXES(NUM_AXES), .STATE_FRAC_BITS(STATE_FRAC_BITS), .AXW(AXW)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.action    (action),
		.meas_x    (meas_x),
		.meas_y    (meas_y),
		.meas_z    (meas_z),
		.cmd       (cmd),
		.axis      (axis),
		.sts       (sts),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_z     (vel_z),
		.saturated (saturated)
	);

endmodule

`default_nettype wire

// ----- rtl/core/kcv_check.sv -----
// Port-level checks for the tracker, bound to the top level.
`default_nettype none

module kcv_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] pos_x,
	input wire logic [31:0] vel_x,
	input wire logic        saturated
);

	// a word in flight blocks further input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	// a result only appears after a busy period
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x) && $stable(vel_x) && $stable(saturated))
		else $error("output word changed while stalled");

endmodule

bind kalman_cv_tracker_3d kcv_check u_kcv_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pos_x     (pos_x),
	.vel_x     (vel_x),
	.saturated (saturated)
);

`default_nettype wire

// ----- tb/kalman_cv_tracker_3d_tb.sv -----
// Testbench for the 3D constant-velocity Kalman tracker: bit-exact predictor with scoreboard.
`timescale 1ns / 100ps

module kalman_cv_tracker_3d_tb;
	import kcv_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [31:0] vel [3];
		logic               sat;
	} track_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	kcv_cfg_t cfg_addr = CFG_DT;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic signed [31:0] meas_x = '0, meas_y = '0, meas_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
	logic saturated;

	kalman_cv_tracker_3d u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.meas_x(meas_x), .meas_y(meas_y), .meas_z(meas_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .saturated(saturated)
	);

	// tracker model state
	logic [63:0] m_dt, m_q, m_r, m_p0;
	logic signed [63:0] m_pos [3];
	logic signed [63:0] m_vel [3];
	logic signed [63:0] m_cov [9];
	logic m_sat;

	track_word_t estimate_q [$];
	int errors = 0;
	int idle_in_pct = 0;
	int idle_out_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	initial forever #4 clk = ~clk;

	function automatic logic [127:0] mag_of(input logic signed [63:0] x);
		return (x < 0) ? 128'(-x) : 128'(x);
	endfunction

	function automatic logic signed [63:0] to_term(input logic [127:0] mag, input logic neg);
		logic [127:0] lim;
		lim = 128'd1 << (TERM_W - 1);
		if (neg) begin
			if (mag > lim) begin
				m_sat = 1'b1;
				mag = lim;
			end
			return -$signed(mag[63:0]);
		end
		if (mag > lim - 1) begin
			m_sat = 1'b1;
			mag = lim - 1;
		end
		return $signed(mag[63:0]);
	endfunction

	function automatic logic signed [63:0] clamp(input logic signed [63:0] x, input int w);
		logic signed [63:0] hi;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		if (x > hi) begin
			m_sat = 1'b1;
			return hi;
		end
		if (x < -hi - 64'sd1) begin
			m_sat = 1'b1;
			return -hi - 64'sd1;
		end
		return x;
	endfunction

	function automatic logic signed [63:0] scaled_mul(input logic signed [63:0] a,
			input logic signed [63:0] b, input int s);
		logic [127:0] m;
		m = (mag_of(a) * mag_of(b) + (128'd1 << (s - 1))) >> s;
		return to_term(m, (a < 0) != (b < 0));
	endfunction

	function automatic logic signed [63:0] gain(input logic signed [63:0] num,
			input logic signed [63:0] den);
		logic [127:0] n, d, qv;
		n = mag_of(num) << GAIN_FB;
		d = 128'(den);
		qv = n / d;
		if (2 * (n % d) >= d)
			qv = qv + 1;
		return to_term(qv, num < 0);
	endfunction

	function automatic void reload_filter();
		for (int a = 0; a < 3; a++) begin
			m_pos[a] = 0;
			m_vel[a] = 0;
			m_cov[3*a] = $signed(m_p0);
			m_cov[3*a+1] = 0;
			m_cov[3*a+2] = $signed(m_p0);
		end
	endfunction

	function automatic track_word_t track_step(input logic act, input logic signed [31:0] z [3]);
		track_word_t w;
		logic signed [63:0] dt, q, r, p, v, pp, pv, vv, ta, tb, s, kp, kv, y, npp, npv, nvv;
		dt = $signed(m_dt);
		q = $signed(m_q);
		r = $signed(m_r);
		m_sat = 1'b0;
		for (int a = 0; a < 3; a++) begin
			p = m_pos[a];
			v = m_vel[a];
			pp = m_cov[3*a];
			pv = m_cov[3*a+1];
			vv = m_cov[3*a+2];
			p = clamp(p + scaled_mul(dt, v, 16), ST_W);
			ta = clamp(pp + scaled_mul(dt, pv, 16), COV_W);
			tb = clamp(pv + scaled_mul(dt, vv, 16), COV_W);
			pp = clamp(ta + scaled_mul(dt, tb, 16) + q, COV_W);
			pv = tb;
			vv = clamp(vv + q, COV_W);
			s = pp + r;
			if (!act && s > 0) begin
				kp = gain(pp, s);
				kv = gain(pv, s);
				y = 64'(z[a]) - p;
				p = clamp(p + scaled_mul(kp, y, GAIN_FB), ST_W);
				v = clamp(v + scaled_mul(kv, y, GAIN_FB), ST_W);
				npp = clamp(pp - scaled_mul(kp, pp, GAIN_FB), COV_W);
				npv = clamp(pv - scaled_mul(kp, pv, GAIN_FB), COV_W);
				nvv = clamp(vv - scaled_mul(kv, pv, GAIN_FB), COV_W);
				pp = npp;
				pv = npv;
				vv = nvv;
			end
			m_pos[a] = p;
			m_vel[a] = v;
			m_cov[3*a] = pp;
			m_cov[3*a+1] = pv;
			m_cov[3*a+2] = vv;
			w.pos[a] = p[31:0];
			w.vel[a] = v[31:0];
		end
		w.sat = m_sat;
		return w;
	endfunction

	// caller is at a rising edge
	task automatic send_word(input logic act, input logic signed [31:0] x,
			input logic signed [31:0] yv, input logic signed [31:0] zv);
		int gap;
		logic signed [31:0] z [3];
		gap = ($urandom_range(99) < idle_in_pct) ? $urandom_range(4, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		meas_x <= x;
		meas_y <= yv;
		meas_z <= zv;
		do @(posedge clk); while (!in_ready);
		z[0] = x;
		z[1] = yv;
		z[2] = zv;
		estimate_q.push_back(track_step(act, z));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (estimate_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input kcv_cfg_t idx, input logic [CFG_DW-1:0] val);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_DT: m_dt = 64'(val[DT_W-1:0]);
			CFG_Q:  m_q = 64'(val);
			CFG_R:  m_r = 64'(val);
			CFG_P0: begin
				m_p0 = 64'(val);
				reload_filter();
			end
		endcase
	endtask

	function automatic logic [CFG_DW-1:0] rand47();
		return CFG_DW'({$urandom, $urandom});
	endfunction

	task automatic send_random_full();
		send_word(1'($urandom_range(1)), $urandom, $urandom, $urandom);
	endtask

	// noisy constant-velocity target with occasional coasting and wild words
	task automatic run_tracks(input int n);
		int px [3];
		int pv [3];
		for (int a = 0; a < 3; a++) begin
			px[a] = $signed($urandom_range(131072000)) - 65536000;
			pv[a] = $signed($urandom_range(6553600)) - 3276800;
		end
		for (int i = 0; i < n; i++) begin
			for (int a = 0; a < 3; a++)
				px[a] += pv[a] / 10;
			if ($urandom_range(99) < 8)
				send_random_full();
			else
				send_word($urandom_range(99) < 20,
					px[0] + $signed($urandom_range(131072)) - 65536,
					px[1] + $signed($urandom_range(131072)) - 65536,
					px[2] + $signed($urandom_range(131072)) - 65536);
		end
	endtask

	task automatic test_directed();
		send_word(1'b0, 32'sh0001_0000, -32'sh0001_0000, 32'sd0);
		send_word(1'b0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		send_word(1'b1, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
		send_word(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
		send_word(1'b1, 32'sd0, 32'sd0, 32'sd0);
		send_word(1'b0, 32'sd0, -32'sd1, 32'sd1);
		send_word(1'b0, 32'shffff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa);
		send_word(1'b1, 32'sh1234_5678, 32'sh0, 32'sh0);
		wait_idle();
	endtask

	task automatic test_config_extremes();
		write_reg(CFG_DT, {CFG_DW{1'b1}});
		repeat (3) send_word(1'b0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0100_0000);
		send_word(1'b1, 0, 0, 0);
		wait_idle();
		write_reg(CFG_DT, '0);
		write_reg(CFG_Q, {CFG_DW{1'b1}});
		repeat (3) send_word(1'b0, 32'sh0010_0000, -32'sh0010_0000, 32'sh7fff_ffff);
		wait_idle();
		write_reg(CFG_Q, '0);
		write_reg(CFG_R, {CFG_DW{1'b1}});
		write_reg(CFG_P0, {CFG_DW{1'b1}});
		repeat (3) send_word(1'b0, 32'sh8000_0000, 32'sh0000_0001, 32'sh7fff_ffff);
		wait_idle();
		write_reg(CFG_R, 47'd1);
		write_reg(CFG_P0, '0);
		repeat (3) send_word(1'b0, 32'sh0003_0000, 32'sh8000_0000, -32'sh0003_0000);
		wait_idle();
		write_reg(CFG_DT, CFG_DW'(DT_RST));
		write_reg(CFG_Q, Q_RST);
		write_reg(CFG_R, R_RST);
		write_reg(CFG_P0, P0_RST);
		repeat (3) send_random_full();
		wait_idle();
	endtask

	task automatic test_random_phase(input int in_pct, input int out_pct, input int n);
		idle_in_pct = in_pct;
		idle_out_pct = out_pct;
		for (int seg = 0; seg < 6; seg++) begin
			write_reg(CFG_DT, CFG_DW'($urandom_range(131072, 600)));
			write_reg(CFG_Q, 47'($urandom_range(1 << 22)));
			if ($urandom_range(9) == 0)
				write_reg(CFG_R, rand47());
			else
				write_reg(CFG_R, 47'({$urandom_range(3), $urandom}) + 47'd1);
			write_reg(CFG_P0, 47'($urandom_range(1 << 14)) << 32);
			run_tracks(n / 6);
			wait_idle();
		end
	endtask

	task automatic test_output_stall();
		idle_in_pct = 0;
		hold_cycles = 3000;
		run_tracks(8);
		wait_idle();
	endtask

	// result checker and receiver
	always @(posedge clk) begin
		track_word_t e;
		logic signed [31:0] got_pos [3];
		logic signed [31:0] got_vel [3];
		if (out_valid && out_ready) begin
			got_pos = '{pos_x, pos_y, pos_z};
			got_vel = '{vel_x, vel_y, vel_z};
			if (estimate_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: pos %0d %0d %0d", pos_x, pos_y, pos_z);
			end else begin
				e = estimate_q.pop_front();
				if (e.pos != got_pos || e.vel != got_vel || e.sat != saturated) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp pos %0d %0d %0d vel %0d %0d %0d sat %0b, got pos %0d %0d %0d vel %0d %0d %0d sat %0b",
							e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1], e.vel[2],
							e.sat, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, saturated);
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_out_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		m_dt = 64'(DT_RST);
		m_q = 64'(Q_RST);
		m_r = 64'(R_RST);
		m_p0 = 64'(P0_RST);
		reload_filter();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random_phase(28, 56, 650);
		test_random_phase(56, 28, 650);
		test_random_phase(0, 0, 650);
		test_output_stall();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/kcv_pkg.sv
rtl/core/kcv_mul.sv
rtl/core/kcv_div.sv
rtl/core/kcv_dp.sv
rtl/core/kcv_ctrl.sv
rtl/core/kalman_cv_tracker_3d.sv
rtl/core/kcv_check.sv
tb/kalman_cv_tracker_3d_tb.sv
